// ----- design/ioc_pkg.sv -----
// ----------------------------------------------------------------------------
// ioc_pkg: shared types for the in-order filter commit block
// Beat layouts of both channels, the command passed from front to back,
// and the status codes.
// ----------------------------------------------------------------------------
package ioc_pkg;

  localparam int CntW = 7;

  typedef enum logic {
    ActPost = 1'b0,
    ActRead = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StatOk     = 2'd0,
    StatStale  = 2'd1,
    StatBeyond = 2'd2,
    StatFull   = 2'd3
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] seq;
    logic        pass;
    logic [15:0] start_index;
    logic [5:0]  read_count;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] frame_id;
    logic        entry_valid;
    logic        last;
    logic [31:0] head_seq;
    logic [16:0] list_size;
    logic        advanced;
    status_e     status;
  } out_beat_t;

  typedef struct packed {
    action_e          action;
    logic [31:0]      seq;
    logic             pass;
    logic [15:0]      start;
    logic [CntW-1:0]  cnt;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic take;
  } cmd_hs_t;

endpackage

// ----- design/ioc_ram.sv -----
// ----------------------------------------------------------------------------
// ioc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data; a read of the
// address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module ioc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ioc_front.sv -----
// ----------------------------------------------------------------------------
// ioc_front: input side of the in-order filter commit block
// Accepts input beats, decodes and clamps them into commands and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ioc_front #(
  parameter int MAX_READ = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ioc_pkg::in_beat_t item_i,
  output ioc_pkg::cmd_t     cmd_o,
  input  ioc_pkg::cmd_hs_t  hs_i,
  output logic              cmd_valid_o
);
  import ioc_pkg::*;

  localparam logic [CntW-1:0] MaxRd = CntW'(MAX_READ);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       dec;
  logic       do_push, do_pop;
  logic [CntW-1:0] req_cnt;

  assign req_cnt = CntW'(item_i.read_count);

  always_comb begin
    dec.action = item_i.action;
    dec.seq    = item_i.seq;
    dec.pass   = item_i.pass;
    dec.start  = item_i.start_index;
    dec.cnt    = (req_cnt > MaxRd) ? MaxRd : req_cnt;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = hs_i.take && hs_i.valid;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// ----- design/ioc_back.sv -----
// ----------------------------------------------------------------------------
// ioc_back: execution side of the in-order filter commit block
// Parks verdicts in the window, walks the head forward one entry a cycle,
// appends passing numbers to the match list and streams read bursts.
// ----------------------------------------------------------------------------
module ioc_back #(
  parameter int WINDOW     = 256,
  parameter int LIST_DEPTH = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  ioc_pkg::cmd_t      cmd_i,
  output ioc_pkg::cmd_hs_t   hs_o,
  output logic               empty,
  input  logic               pop,
  output ioc_pkg::out_beat_t result_o
);
  import ioc_pkg::*;

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int LW = $clog2(LIST_DEPTH + 1);
  localparam int CW = (LW > 17) ? LW : 17;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StPark   = 3'd2;
  localparam logic [2:0] StDrain  = 3'd3;
  localparam logic [2:0] StEmit   = 3'd4;
  localparam logic [2:0] StRdSize = 3'd5;
  localparam logic [2:0] StRdAddr = 3'd6;
  localparam logic [2:0] StRdData = 3'd7;

  logic [2:0]        state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [WINDOW-1:0] present_q, present_d;
  logic [31:0]       head_q, head_d;
  logic [SW-1:0]     head_slot_q, head_slot_d;
  logic [LW-1:0]     len_q, len_d;
  status_e           status_q, status_d;
  logic              adv_q, adv_d;
  logic [SW-1:0]     off_q, off_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [CW-1:0]     addr_q, addr_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  logic [32:0]   diff;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] park_slot;
  logic [CW-1:0] avail;
  logic [CW-1:0] len_ext;
  logic          slot_free;
  logic          ram_we, ram_re;
  logic [31:0]   ram_rdata;
  logic          pass_we;
  logic          pass_rdata;

  assign diff      = {1'b0, cmd_q.seq} - {1'b0, head_q};
  assign slot_sum  = {1'b0, head_slot_q} + {1'b0, off_q};
  assign park_slot = (slot_sum >= (SW + 1)'(WINDOW)) ? SW'(slot_sum - (SW + 1)'(WINDOW))
                                                     : SW'(slot_sum);
  assign len_ext   = CW'(len_q);
  assign avail     = (CW'(cmd_q.start) < len_ext) ? len_ext - CW'(cmd_q.start) : '0;
  assign slot_free = !out_valid_q || pop;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    present_d   = present_q;
    head_d      = head_q;
    head_slot_d = head_slot_q;
    len_d       = len_q;
    status_d    = status_q;
    adv_d       = adv_q;
    off_d       = off_q;
    rem_d       = rem_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    hs_o.valid  = cmd_valid_i;
    hs_o.take   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    pass_we     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          hs_o.take = 1'b1;
          cmd_d     = cmd_i;
          status_d  = StatOk;
          adv_d     = 1'b0;
          state_d   = (cmd_i.action == ActRead) ? StRdSize : StCheck;
        end
      end
      StCheck: begin
        off_d = SW'(diff - 33'd1);
        if (cmd_q.seq <= head_q) begin
          status_d = StatStale;
          state_d  = StDrain;
        end else if (diff > 33'(WINDOW)) begin
          status_d = StatBeyond;
          state_d  = StDrain;
        end else begin
          state_d = StPark;
        end
      end
      StPark: begin
        if (present_q[park_slot]) begin
          status_d = StatStale;
        end else begin
          present_d[park_slot] = 1'b1;
          pass_we              = 1'b1;
        end
        state_d = StDrain;
      end
      StDrain: begin
        // pass_rdata holds the verdict of head_slot_q, fetched at the last edge
        if ((head_q != '1) && present_q[head_slot_q]) begin
          if (pass_rdata) begin
            if (len_q < LW'(LIST_DEPTH)) begin
              ram_we = 1'b1;
              len_d  = len_q + 1'b1;
            end else begin
              status_d = StatFull;
            end
          end
          present_d[head_slot_q] = 1'b0;
          head_d      = head_q + 32'd1;
          head_slot_d = (head_slot_q == SW'(WINDOW - 1)) ? '0 : head_slot_q + 1'b1;
          adv_d       = 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.frame_id    = '0;
          out_d.entry_valid = 1'b0;
          out_d.last        = 1'b1;
          out_d.head_seq    = head_q;
          out_d.list_size   = 17'(len_q);
          out_d.advanced    = adv_q;
          out_d.status      = status_q;
          state_d           = StIdle;
        end
      end
      StRdSize: begin
        addr_d = CW'(cmd_q.start);
        if (avail < CW'(cmd_q.cnt)) begin
          rem_d = CntW'(avail);
        end else begin
          rem_d = cmd_q.cnt;
        end
        state_d = ((avail == '0) || (cmd_q.cnt == '0)) ? StEmit : StRdAddr;
      end
      StRdAddr: begin
        ram_re  = 1'b1;
        state_d = StRdData;
      end
      StRdData: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.frame_id    = ram_rdata;
          out_d.entry_valid = 1'b1;
          out_d.last        = (rem_q == CntW'(1));
          out_d.head_seq    = head_q;
          out_d.list_size   = 17'(len_q);
          out_d.advanced    = 1'b0;
          out_d.status      = StatOk;
          rem_d             = rem_q - 1'b1;
          addr_d            = addr_q + 1'b1;
          state_d           = (rem_q == CntW'(1)) ? StIdle : StRdAddr;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      present_q   <= '0;
      head_q      <= '0;
      head_slot_q <= SW'(1);
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      head_q      <= head_d;
      head_slot_q <= head_slot_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    adv_q    <= adv_d;
    off_q    <= off_d;
    rem_q    <= rem_d;
    addr_q   <= addr_d;
    out_q    <= out_d;
  end

  ioc_ram #(
    .WIDTH(1),
    .DEPTH(WINDOW)
  ) u_pass (
    .clk_i   (clk_i),
    .we_i    (pass_we),
    .waddr_i (park_slot),
    .wdata_i (cmd_q.pass),
    .re_i    (1'b1),
    .raddr_i (head_slot_d),
    .rdata_o (pass_rdata)
  );

  ioc_ram #(
    .WIDTH(32),
    .DEPTH(LIST_DEPTH)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(len_q)),
    .wdata_i (head_d),
    .re_i    (ram_re),
    .raddr_i (AW'(addr_q)),
    .rdata_o (ram_rdata)
  );

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

// ----- design/in_order_filter_commit.sv -----
// ----------------------------------------------------------------------------
// in_order_filter_commit: in-order commit of out-of-order filter verdicts
// Posts park verdicts in a reorder window and retire them in sequence
// order into a match list; reads return bursts of match list entries.
// ----------------------------------------------------------------------------
//  channel  | handshake          | beat
//  ---------+--------------------+----------------------------------------
//  input    | push / full        | item_i   (ioc_pkg::in_beat_t)
//  result   | pop / empty        | result_o (ioc_pkg::out_beat_t)
//
//  Post: checks the sequence, parks the verdict, retires present window
//  entries in order and emits a status beat; a stale or out-of-window post
//  skips the park. Read: returns list entries; an empty read one status beat.
//  The executor handles one command at a time; the two-entry command queue
//  takes new beats while it works. Reset clears the window bits at once;
//  the match list is not cleared. A stalled result holds the executor.
module in_order_filter_commit #(
  parameter int WINDOW     = 256,
  parameter int LIST_DEPTH = 65536,
  parameter int MAX_READ   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ioc_pkg::in_beat_t  item_i,
  output logic               empty,
  input  logic               pop,
  output ioc_pkg::out_beat_t result_o
);
  import ioc_pkg::*;

  cmd_t    cmd;
  cmd_hs_t hs;
  logic    cmd_valid;

  ioc_front #(
    .MAX_READ(MAX_READ)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_o       (cmd),
    .hs_i        (hs),
    .cmd_valid_o (cmd_valid)
  );

  ioc_back #(
    .WINDOW    (WINDOW),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .hs_o        (hs),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

// ----- design/ioc_checker.sv -----
// ----------------------------------------------------------------------------
// ioc_checker: port-level checks for the in-order filter commit block
// Watches the result channel and checks beat consistency over time.
// ----------------------------------------------------------------------------
module ioc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input ioc_pkg::out_beat_t result_o
);
  import ioc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result beat changed while stalled");

  a_read_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.entry_valid) |->
      (!result_o.advanced && result_o.status == StatOk &&
       result_o.frame_id != 32'd0 && result_o.frame_id <= result_o.head_seq))
    else $error("list entry beat inconsistent with committed head");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.entry_valid) |->
      (result_o.last && result_o.frame_id == 32'd0))
    else $error("non-entry beat must be a lone final beat");

  a_no_adv_on_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.status == StatStale || result_o.status == StatBeyond)) |->
      !result_o.advanced)
    else $error("dropped post moved the head");

  a_adv_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.advanced) |-> (result_o.head_seq != 32'd0))
    else $error("head advanced but reads zero");

endmodule

bind in_order_filter_commit ioc_checker u_checker (.*);
